>>> sv/ttr_pkg.sv
// ============================================================================
// ttr_pkg: shared types and constants of the tile triangle rasterizer
// Holds the setup record passed from the triangle front end to the row engine.
// ============================================================================
`default_nettype none
package ttr_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TILE_X = 2'd0;
  localparam logic [1:0] CFG_TILE_Y = 2'd1;
  localparam logic [1:0] CFG_SCR_W  = 2'd2;
  localparam logic [1:0] CFG_SCR_H  = 2'd3;

  // Front-end sequencer states.
  typedef enum logic [1:0] {
    FE_IDLE,
    FE_BOX,
    FE_PUSH
  } fe_state_t;

  // One triangle after setup, clipped box in screen pixels.
  typedef struct packed {
    logic signed [15:0] vx0;
    logic signed [15:0] vy0;
    logic signed [15:0] vx1;
    logic signed [15:0] vy1;
    logic signed [15:0] vx2;
    logic signed [15:0] vy2;
    logic [12:0]        cx0;
    logic [12:0]        cx1;
    logic [12:0]        cy0;
    logic [12:0]        cy1;
    logic [11:0]        sx0;
    logic [31:0]        argb;
  } setup_t;

  // Clamp a Q2.10 channel to 0..1 and scale to a byte.
  function automatic logic [7:0] chan_byte(input logic signed [11:0] c);
    logic [10:0] cl;
    logic [18:0] prod;
    if (c < 0) cl = 11'd0;
    else if (c > 12'sd1024) cl = 11'd1024;
    else cl = c[10:0];
    prod = {8'd0, cl} * 19'd255;
    return prod[17:10];
  endfunction

endpackage
`default_nettype wire

>>> sv/ttr_fifo.sv
// ============================================================================
// ttr_fifo: small setup queue
// Two-entry queue between the triangle front end and the row engine.
// ============================================================================
`default_nettype none
module ttr_fifo
  import ttr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   wr_valid,
  output logic        wr_ready,
  input  wire setup_t wr_data,
  output logic        rd_valid,
  input  wire logic   rd_ready,
  output setup_t      rd_data
);

  setup_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

>>> sv/ttr_front.sv
// ============================================================================
// ttr_front: triangle setup
// Accepts a triangle, computes the clipped bounding box and packed color.
// ============================================================================
`default_nettype none
module ttr_front
  import ttr_pkg::*;
#(
  parameter int TILE_SIZE     = 64,
  parameter int SUBPIXEL_BITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [95:0] in_vert,
  input  wire logic [35:0] in_color,
  input  wire logic [11:0] tile_x,
  input  wire logic [11:0] tile_y,
  input  wire logic [12:0] scr_w,
  input  wire logic [12:0] scr_h,
  output logic             q_valid,
  input  wire logic        q_ready,
  output setup_t           q_data
);

  localparam int ONE = 1 << SUBPIXEL_BITS;

  fe_state_t state_r, state_nxt;
  logic signed [15:0] v_r [6];
  logic [35:0]        col_r;
  setup_t             set_r;
  logic               empty_r;

  logic signed [15:0] mnx, mxx, mny, mxy;
  logic signed [17:0] fx0, cx1s, fy0, cy1s;
  logic signed [17:0] bx0, bx1, by0, by1;
  logic signed [17:0] sx1, sy1;

  // Floor / ceiling in pixels by arithmetic shift.
  function automatic logic signed [17:0] fl(input logic signed [15:0] v);
    return 18'(v >>> SUBPIXEL_BITS);
  endfunction
  function automatic logic signed [17:0] cl(input logic signed [15:0] v);
    logic signed [17:0] t;
    t = 18'(v) + 18'(ONE - 1);
    return t >>> SUBPIXEL_BITS;
  endfunction

  // Bounding box and clipping from the registered vertices.
  always_comb begin
    mnx = v_r[0]; mxx = v_r[0]; mny = v_r[1]; mxy = v_r[1];
    if (v_r[2] < mnx) mnx = v_r[2];
    if (v_r[4] < mnx) mnx = v_r[4];
    if (v_r[2] > mxx) mxx = v_r[2];
    if (v_r[4] > mxx) mxx = v_r[4];
    if (v_r[3] < mny) mny = v_r[3];
    if (v_r[5] < mny) mny = v_r[5];
    if (v_r[3] > mxy) mxy = v_r[3];
    if (v_r[5] > mxy) mxy = v_r[5];
    fx0  = fl(mnx);
    cx1s = cl(mxx);
    fy0  = fl(mny);
    cy1s = cl(mxy);
    sx1 = 18'({6'd0, tile_x}) + 18'(TILE_SIZE);
    if (18'({5'd0, scr_w}) < sx1) sx1 = 18'({5'd0, scr_w});
    sy1 = 18'({6'd0, tile_y}) + 18'(TILE_SIZE);
    if (18'({5'd0, scr_h}) < sy1) sy1 = 18'({5'd0, scr_h});
    bx0 = (fx0 < $signed(18'({6'd0, tile_x}))) ? $signed(18'({6'd0, tile_x})) : fx0;
    by0 = (fy0 < $signed(18'({6'd0, tile_y}))) ? $signed(18'({6'd0, tile_y})) : fy0;
    bx1 = (cx1s > sx1) ? sx1 : cx1s;
    by1 = (cy1s > sy1) ? sy1 : cy1s;
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FE_IDLE: if (in_valid) state_nxt = FE_BOX;
      FE_BOX:  state_nxt = FE_PUSH;
      FE_PUSH: if (empty_r || q_ready) state_nxt = FE_IDLE;
      default: state_nxt = FE_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    q_valid  = 1'b0;
    unique case (state_r)
      FE_IDLE: in_ready = 1'b1;
      FE_PUSH: q_valid  = !empty_r;
      default: ;
    endcase
  end

  assign q_data = set_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= FE_IDLE;
    else        state_r <= state_nxt;
  end

  // Capture the triangle, then the setup record.
  always_ff @(posedge clk) begin
    if (state_r == FE_IDLE && in_valid) begin
      for (int i = 0; i < 6; i++) v_r[i] <= in_vert[16*i +: 16];
      col_r <= in_color;
    end
    if (state_r == FE_BOX) begin
      empty_r   <= (bx0 >= bx1) || (by0 >= by1);
      set_r.vx0 <= v_r[0]; set_r.vy0 <= v_r[1];
      set_r.vx1 <= v_r[2]; set_r.vy1 <= v_r[3];
      set_r.vx2 <= v_r[4]; set_r.vy2 <= v_r[5];
      set_r.cx0 <= bx0[12:0]; set_r.cx1 <= bx1[12:0];
      set_r.cy0 <= by0[12:0]; set_r.cy1 <= by1[12:0];
      set_r.sx0 <= tile_x;
      set_r.argb <= {8'hFF, chan_byte(col_r[11:0]), chan_byte(col_r[23:12]),
                     chan_byte(col_r[35:24])};
    end
  end

endmodule
`default_nettype wire

>>> sv/ttr_rows.sv
// ============================================================================
// ttr_rows: row engine
// Walks the rows of a set-up triangle and tests all tile pixels in parallel.
// ============================================================================
`default_nettype none
module ttr_rows
  import ttr_pkg::*;
#(
  parameter int TILE_SIZE     = 64,
  parameter int SUBPIXEL_BITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire setup_t      q_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_row,
  output logic [63:0]      out_mask,
  output logic [31:0]      out_argb,
  output logic             out_last
);

  localparam int ONE = 1 << SUBPIXEL_BITS;

  logic        busy_r;
  setup_t      s_r;
  logic [12:0] row_r;
  logic [12:0] last_r;
  logic signed [17:0] stp_r [3];
  logic signed [41:0] base_r [3];   // edge value minus the x term, per row
  logic        ov_r, ol_r;
  logic [11:0] orow_r;
  logic [63:0] omask_r;
  logic [31:0] oargb_r;
  logic        take, emit;
  logic [63:0] mask;
  logic signed [15:0] vx [3];
  logic signed [15:0] vy [3];

  assign vx[0] = s_r.vx0; assign vx[1] = s_r.vx1; assign vx[2] = s_r.vx2;
  assign vy[0] = s_r.vy0; assign vy[1] = s_r.vy1; assign vy[2] = s_r.vy2;

  assign q_ready = !busy_r;
  assign take    = q_valid && !busy_r;
  assign emit    = busy_r && (!ov_r || out_ready);

  // Per-pixel coverage: e = step*(px2 - 2vx[p]) + base, px2 = (2x+1)*ONE.
  always_comb begin
    mask = '0;
    for (int i = 0; i < TILE_SIZE; i++) begin
      logic [12:0] xs;
      logic signed [19:0] px2;
      logic ok;
      xs  = 13'({1'b0, s_r.sx0}) + 13'(i);
      px2 = 20'(({7'd0, xs} * 20'd2 + 20'd1) * 20'(ONE));
      ok  = (xs >= s_r.cx0) && (xs < s_r.cx1);
      for (int k = 0; k < 3; k++) begin
        logic signed [41:0] e;
        e = 42'(stp_r[k] * (px2 - 20'(2 * vx[(k + 1) % 3]))) + base_r[k];
        if (e < 0) ok = 1'b0;
      end
      mask[i] = ok;
    end
  end

  // Row walker.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (take) begin
        busy_r <= 1'b1;
        row_r  <= q_data.cy0;
        last_r <= q_data.cy1 - 13'd1;
        s_r    <= q_data;
        stp_r[0] <= 18'(q_data.vy1) - 18'(q_data.vy2);
        stp_r[1] <= 18'(q_data.vy2) - 18'(q_data.vy0);
        stp_r[2] <= 18'(q_data.vy0) - 18'(q_data.vy1);
      end else if (emit) begin
        orow_r  <= row_r[11:0];
        omask_r <= mask;
        oargb_r <= s_r.argb;
        ol_r    <= (row_r == last_r);
        if (row_r == last_r) busy_r <= 1'b0;
        row_r <= row_r + 13'd1;
      end
    end
  end

  // Row constant term: (vx[q]-vx[p]) * (py2 - 2vy[p]).
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [17:0] dx;
      logic signed [19:0] py2;
      dx  = 18'(vx[(k + 2) % 3]) - 18'(vx[(k + 1) % 3]);
      py2 = 20'(({7'd0, (take ? q_data.cy0 : (emit ? row_r + 13'd1 : row_r))}
                 * 20'd2 + 20'd1) * 20'(ONE));
      if (take) begin
        dx = 18'(q_data.vx0);
        unique case (k)
          0: dx = 18'(q_data.vx2) - 18'(q_data.vx1);
          1: dx = 18'(q_data.vx0) - 18'(q_data.vx2);
          default: dx = 18'(q_data.vx1) - 18'(q_data.vx0);
        endcase
        unique case (k)
          0: base_r[k] <= 42'(dx * (py2 - 20'(2 * q_data.vy1)));
          1: base_r[k] <= 42'(dx * (py2 - 20'(2 * q_data.vy2)));
          default: base_r[k] <= 42'(dx * (py2 - 20'(2 * q_data.vy0)));
        endcase
      end else begin
        base_r[k] <= 42'(dx * (py2 - 20'(2 * vy[(k + 1) % 3])));
      end
    end
  end

  assign out_valid = ov_r;
  assign out_row   = orow_r;
  assign out_mask  = omask_r;
  assign out_argb  = oargb_r;
  assign out_last  = ol_r;

endmodule
`default_nettype wire

>>> sv/tile_triangle_rasterizer.sv
// Throughput: one row result per cycle while m_axis_tready does not stall it;
// the row engine loads each triangle before its first row, and the front end
// takes no new triangle until its current one has left its push state.
// Front end and row engine are parted by a two-entry setup queue.
// Reset (rst_n, synchronous, active low) empties all channels and loads the
// registers with tile origin 0,0 and screen size 1024 x 768.
// ============================================================================
// tile_triangle_rasterizer: edge-function triangle rasterizer for one tile
// Gives one coverage mask and color per row of the clipped bounding box.
// ============================================================================
`default_nettype none
module tile_triangle_rasterizer
  import ttr_pkg::*;
#(
  parameter int TILE_SIZE     = 64,
  parameter int SUBPIXEL_BITS = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [12:0]  cfg_data,
  // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
  // color_red, color_green, color_blue, then 4 zero bits
  input  wire logic [135:0] s_axis_tdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // row_y, coverage_mask, packed_argb, then 4 zero bits
  output logic [111:0]      m_axis_tdata,
  output logic              m_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready
);

  logic [11:0] tx_r, ty_r;
  logic [12:0] sw_r, sh_r;
  logic        qv, qr, fv, fr;
  setup_t      qd, fd;
  logic [11:0] orow;
  logic [63:0] omask;
  logic [31:0] oargb;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r <= '0; ty_r <= '0; sw_r <= 13'd1024; sh_r <= 13'd768;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TILE_X: tx_r <= cfg_data[11:0];
        CFG_TILE_Y: ty_r <= cfg_data[11:0];
        CFG_SCR_W:  sw_r <= cfg_data;
        CFG_SCR_H:  sh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ttr_front #(.TILE_SIZE(TILE_SIZE), .SUBPIXEL_BITS(SUBPIXEL_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_vert(s_axis_tdata[95:0]), .in_color(s_axis_tdata[131:96]),
    .tile_x(tx_r), .tile_y(ty_r), .scr_w(sw_r), .scr_h(sh_r),
    .q_valid(qv), .q_ready(qr), .q_data(qd)
  );

  ttr_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(qv), .wr_ready(qr), .wr_data(qd),
    .rd_valid(fv), .rd_ready(fr), .rd_data(fd)
  );

  ttr_rows #(.TILE_SIZE(TILE_SIZE), .SUBPIXEL_BITS(SUBPIXEL_BITS)) u_rows (
    .clk(clk), .rst_n(rst_n), .q_valid(fv), .q_ready(fr), .q_data(fd),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_row(orow),
    .out_mask(omask), .out_argb(oargb), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, oargb, omask, orow};

`ifndef SYNTH
  // The alpha byte of a delivered result is always opaque.
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid |-> m_axis_tdata[107:100] == 8'hFF) else $error("alpha");
  // A result held under backpressure keeps its row.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata[11:0]))
    else $error("row hold");
`endif

endmodule
`default_nettype wire
